>>> hw/rtl/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types and constants of the pointer metadata table.
// ----------------------------------------------------------------------------
package pmt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned LOCK_SLOTS  = 16;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned LOCK_W      = 4;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned SLOT_W      = $clog2(LOCK_SLOTS);

  localparam logic [KEY_W-1:0] NULL_KEY  = '0;
  localparam logic [KEY_W-1:0] KEY_RESET = NULL_KEY + KEY_W'(1);

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_DEL  = 2'd1;
  localparam logic [1:0] CMD_FIND = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] bound;
    logic [KEY_W-1:0]  key;
    logic [LOCK_W-1:0] lock;
    logic              freeable;
  } entry_t;

endpackage

>>> hw/rtl/pmt_if.sv
// ----------------------------------------------------------------------------
// pmt_req_if / pmt_rsp_if
// Valid/ready channels carrying a request word and a result word.
// ----------------------------------------------------------------------------
interface pmt_req_if;
  import pmt_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [ADDR_W-1:0] ptr_addr;
  logic [ADDR_W-1:0] region_base;
  logic [ADDR_W-1:0] region_bound;
  logic              may_free;

  modport source (output valid, command, ptr_addr, region_base, region_bound, may_free,
                  input ready);
  modport sink   (input valid, command, ptr_addr, region_base, region_bound, may_free,
                  output ready);
endinterface

interface pmt_rsp_if;
  import pmt_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] meta_base;
  logic [ADDR_W-1:0] meta_bound;
  logic [KEY_W-1:0]  meta_key;
  logic [LOCK_W-1:0] meta_lock;
  logic              meta_freeable;
  logic              free_request;

  modport source (output valid, status, meta_base, meta_bound, meta_key, meta_lock,
                  meta_freeable, free_request, input ready);
  modport sink   (input valid, status, meta_base, meta_bound, meta_key, meta_lock,
                  meta_freeable, free_request, output ready);
endinterface

>>> hw/rtl/pointer_metadata_table_core.sv
// ----------------------------------------------------------------------------
// pointer_metadata_table_core
// Ordered pointer metadata table, newest entry first.
// ----------------------------------------------------------------------------
// Request words (add, delete, find) arrive on req_i, one result word per
// request leaves on rsp_o. Addresses and the order of entries sit in a
// shifting register file that is searched in parallel; the metadata of each
// entry lives in a synchronous RAM indexed by a physical slot.
// A request passes a search step with the RAM read and an update step;
// its result word is captured in the result register when the update is done.
// The next request is accepted in the cycle after the update at the
// earliest: no request is taken while the last one is in progress.
// The result register decouples the sides: a stalled receiver holds the
// finished word while the next request is accepted and searched; its update
// waits until the result register is free.
// Reset empties the table, frees all lock slots and sets the key counter to
// one past the invalid key. The RAM is not cleared: entries are only read
// through valid positions.
// ----------------------------------------------------------------------------
module pointer_metadata_table_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmt_req_if.sink    req_i,
  pmt_rsp_if.source  rsp_o
);
  import pmt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] st_q, st_d;

  // captured request
  logic [1:0]        cmd_q;
  logic [ADDR_W-1:0] addr_q, base_q, bound_q;
  logic              free_q;

  // ordered table: position 0 is newest
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [ADDR_W-1:0]      taddr_q [TABLE_DEPTH];
  logic [IDX_W-1:0]       tphys_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] phys_busy_q;
  logic [LOCK_SLOTS-1:0]  lock_busy_q;
  logic [KEY_W-1:0]       ctr_q;

  // search result
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] phys_q;

  // metadata RAM
  entry_t           mem_q [TABLE_DEPTH];
  entry_t           rd_q;
  entry_t           wdata;
  logic             we;
  logic [IDX_W-1:0] waddr;

  // result register
  logic              rsp_valid_q;
  logic [1:0]        r_status_q;
  entry_t            r_ent_q;
  logic              r_freq_q;

  logic              accept, done, out_free;
  logic [ADDR_W-1:0] look_key;
  logic              lock_found, phys_found;
  logic [SLOT_W-1:0] lock_slot;
  logic [IDX_W-1:0]  free_phys;
  logic              do_ins, do_del;
  logic [1:0]        status_d;
  entry_t            ent_d;
  logic              freq_d;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign done     = (st_q == S_EXEC) && out_free;
  assign req_i.ready = (st_q == S_IDLE);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:  if (accept) st_d = S_LOOK;
      S_LOOK:  st_d = S_EXEC;
      S_EXEC:  if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // parallel search, newest match wins
  assign look_key = (cmd_q == CMD_ADD) ? base_q : addr_q;
  always_comb begin
    hit_d = 1'b0;
    pos_d = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (valid_q[k] && taddr_q[k] == look_key) begin
        hit_d = 1'b1;
        pos_d = IDX_W'(k);
      end
    end
  end

  always_comb begin
    lock_found = 1'b0;
    lock_slot  = '0;
    for (int k = LOCK_SLOTS - 1; k >= 0; k--) begin
      if (!lock_busy_q[k]) begin
        lock_found = 1'b1;
        lock_slot  = SLOT_W'(k);
      end
    end
    phys_found = 1'b0;
    free_phys  = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (!phys_busy_q[k]) begin
        phys_found = 1'b1;
        free_phys  = IDX_W'(k);
      end
    end
  end

  // update decision
  always_comb begin
    status_d = ST_OK;
    ent_d    = '0;
    freq_d   = 1'b0;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    if (cmd_q == CMD_ADD) begin
      if (addr_q == '0) begin
        status_d = ST_NULL;
      end else if (valid_q[TABLE_DEPTH-1] || !phys_found) begin
        status_d = ST_FULL;
      end else if (hit_q) begin
        ent_d          = rd_q;
        ent_d.freeable = free_q;
        do_ins         = 1'b1;
      end else if (!lock_found) begin
        status_d = ST_FULL;
      end else begin
        ent_d.base     = base_q;
        ent_d.bound    = bound_q;
        ent_d.key      = ctr_q + KEY_W'(1);
        ent_d.lock     = LOCK_W'(lock_slot);
        ent_d.freeable = free_q;
        do_ins         = 1'b1;
      end
    end else if (!hit_q) begin
      status_d = ST_NOTFOUND;
    end else begin
      ent_d = rd_q;
      if (cmd_q == CMD_DEL) begin
        freq_d = rd_q.freeable;
        do_del = 1'b1;
      end
    end
  end

  assign we    = done && do_ins;
  assign waddr = free_phys;
  assign wdata = ent_d;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (st_q == S_LOOK) rd_q <= mem_q[tphys_q[pos_d]];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= req_i.command;
      addr_q  <= req_i.ptr_addr;
      base_q  <= req_i.region_base;
      bound_q <= req_i.region_bound;
      free_q  <= req_i.may_free;
    end
    if (st_q == S_LOOK) begin
      hit_q  <= hit_d;
      pos_q  <= pos_d;
      phys_q <= tphys_q[pos_d];
    end
    if (done) begin
      r_status_q <= status_d;
      r_ent_q    <= ent_d;
      r_freq_q   <= freq_d;
    end
    if (done && do_ins) begin
      for (int k = TABLE_DEPTH - 1; k > 0; k--) begin
        taddr_q[k] <= taddr_q[k-1];
        tphys_q[k] <= tphys_q[k-1];
      end
      taddr_q[0] <= addr_q;
      tphys_q[0] <= free_phys;
    end else if (done && do_del) begin
      for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
        if (IDX_W'(k) >= pos_q) begin
          taddr_q[k] <= taddr_q[k+1];
          tphys_q[k] <= tphys_q[k+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      valid_q     <= '0;
      phys_busy_q <= '0;
      lock_busy_q <= '0;
      ctr_q       <= KEY_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (done) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (done && do_ins) begin
        valid_q              <= {valid_q[TABLE_DEPTH-2:0], 1'b1};
        phys_busy_q[free_phys] <= 1'b1;
        if (!hit_q) begin
          ctr_q                 <= ctr_q + KEY_W'(1);
          lock_busy_q[lock_slot] <= 1'b1;
        end
      end else if (done && do_del) begin
        valid_q                <= {1'b0, valid_q[TABLE_DEPTH-1:1]} | (valid_q &
                                  ((TABLE_DEPTH'(1) << pos_q) - TABLE_DEPTH'(1)));
        phys_busy_q[phys_q]    <= 1'b0;
        // shared slots are released too
        lock_busy_q[SLOT_W'(rd_q.lock)] <= 1'b0;
      end
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = r_status_q;
  assign rsp_o.meta_base     = r_ent_q.base;
  assign rsp_o.meta_bound    = r_ent_q.bound;
  assign rsp_o.meta_key      = r_ent_q.key;
  assign rsp_o.meta_lock     = r_ent_q.lock;
  assign rsp_o.meta_freeable = r_ent_q.freeable;
  assign rsp_o.free_request  = r_freq_q;

endmodule
